[src/ptt_pkg.sv]
// ----------------------------------------------------------------------------
// Periodic timer table package
// Shared sizes, codes and the entry and cell command types.
// ----------------------------------------------------------------------------
package ptt_pkg;

   localparam int MAX_TIMERS   = 16;
   localparam int TICK_BITS    = 32;
   localparam int NOW_BITS     = 32;
   localparam int PERIOD_BITS  = 32;
   localparam int HANDLE_BITS  = 4;
   localparam int HANDLE_COUNT = 16;
   localparam int OPCODE_BITS  = 2;
   localparam int KIND_BITS    = 2;
   localparam int CNT_BITS     = $clog2(MAX_TIMERS + 1);
   localparam int IDX_BITS     = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
   localparam int CMP_BITS     = (TICK_BITS > PERIOD_BITS) ? TICK_BITS : PERIOD_BITS;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_REGISTER   = 2'd0,
      OP_UNREGISTER = 2'd1,
      OP_TICK       = 2'd2,
      OP_NOP        = 2'd3
   } opcode_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_REGISTERED = 2'd0,
      KIND_FIRED      = 2'd1,
      KIND_DONE       = 2'd2,
      KIND_FULL       = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [HANDLE_BITS-1:0] handle;
      logic [PERIOD_BITS-1:0] period;
      logic [TICK_BITS-1:0]   last;
   } entry_type;

   typedef struct packed {
      logic [MAX_TIMERS-1:0]  load_en;
      logic [MAX_TIMERS-1:0]  shift_en;
      entry_type              load_entry;
      entry_type              wrap_entry;
      logic [HANDLE_BITS-1:0] match_id;
   } cell_cmd_type;

endpackage

[src/ptt_cell.sv]
// ----------------------------------------------------------------------------
// Timer cell
// Holds one list entry; loads a new timer or takes its upper neighbor's entry.
// ----------------------------------------------------------------------------
module ptt_cell (
   input  logic                            clock,
   input  logic                            load_en,
   input  logic                            shift_en,
   input  ptt_pkg::entry_type              load_entry,
   input  ptt_pkg::entry_type              next_entry,
   input  logic [ptt_pkg::HANDLE_BITS-1:0] match_id,
   output ptt_pkg::entry_type              entry,
   output logic                            match
);
   import ptt_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // pick load, neighbor shift or hold
   always_comb begin
      entry_in = entry_ff;
      if (load_en) begin
         entry_in = load_entry;
      end else if (shift_en) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign match = (entry_ff.handle == match_id);

endmodule

[src/ptt_seq.sv]
// ----------------------------------------------------------------------------
// Timer table sequencer
// Decodes commands, tracks count and handles, drives the cell row and results.
// ----------------------------------------------------------------------------
module ptt_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [ptt_pkg::OPCODE_BITS-1:0] req_opcode,
   input  logic [ptt_pkg::NOW_BITS-1:0]    req_now_tick,
   input  logic [ptt_pkg::PERIOD_BITS-1:0] req_period,
   input  logic [ptt_pkg::HANDLE_BITS-1:0] req_timer_id,
   input  ptt_pkg::entry_type              head_entry,
   input  logic [ptt_pkg::MAX_TIMERS-1:0]  match_vec,
   output ptt_pkg::cell_cmd_type           cmd,
   output logic                            rsp_strobe,
   output logic [ptt_pkg::KIND_BITS-1:0]   rsp_kind,
   output logic [ptt_pkg::HANDLE_BITS-1:0] rsp_result_id,
   output logic                            rsp_last_of_run
);
   import ptt_pkg::*;

   state_type               state_ff, state_in;
   logic [IDX_BITS-1:0]     step_ff, step_in;
   logic [TICK_BITS-1:0]    now_ff, now_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [HANDLE_COUNT-1:0] in_use_ff, in_use_in;
   logic                    strobe_ff, strobe_in;
   kind_type                kind_ff, kind_in;
   logic [HANDLE_BITS-1:0]  id_ff, id_in;
   logic                    last_ff, last_in;

   logic [TICK_BITS-1:0]    req_now;
   logic [HANDLE_BITS-1:0]  free_handle;
   logic                    table_full;
   logic [MAX_TIMERS-1:0]   slot_sel;
   logic [MAX_TIMERS-1:0]   shift_mask;
   logic                    found;
   logic [TICK_BITS-1:0]    elapsed;
   logic                    fire;
   entry_type               wrap_entry;

   assign req_now = TICK_BITS'(req_now_tick);

   // find the lowest free handle
   always_comb begin
      free_handle = '0;
      for (int i = HANDLE_COUNT - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_handle = HANDLE_BITS'(i);
         end
      end
   end

   assign table_full = (count_ff == CNT_BITS'(MAX_TIMERS)) || (&in_use_ff);

   // select the append slot and the cells that close the gap on removal
   always_comb begin
      logic run;
      run = 1'b0;
      for (int j = 0; j < MAX_TIMERS; j++) begin
         slot_sel[j] = (count_ff == CNT_BITS'(j));
         run = run | (match_vec[j] & (CNT_BITS'(j) < count_ff));
         shift_mask[j] = run;
      end
      found = run;
   end

   // test the head entry against the latched tick
   assign elapsed = now_ff - head_entry.last;
   assign fire    = (CNT_BITS'(step_ff) < count_ff) &&
                    (CMP_BITS'(elapsed) >= CMP_BITS'(head_entry.period));

   always_comb begin
      wrap_entry = head_entry;
      if (fire) begin
         wrap_entry.last = now_ff;
      end
   end

   // next state, bookkeeping and result beat
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      now_in    = now_ff;
      count_in  = count_ff;
      in_use_in = in_use_ff;
      strobe_in = 1'b0;
      kind_in   = KIND_DONE;
      id_in     = '0;
      last_in   = 1'b1;

      cmd.load_en           = '0;
      cmd.shift_en          = '0;
      cmd.load_entry.handle = free_handle;
      cmd.load_entry.period = req_period;
      cmd.load_entry.last   = req_now;
      cmd.wrap_entry        = wrap_entry;
      cmd.match_id          = req_timer_id;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (opcode_type'(req_opcode))
                  OP_REGISTER: begin
                     strobe_in = 1'b1;
                     if (table_full) begin
                        kind_in = KIND_FULL;
                     end else begin
                        kind_in     = KIND_REGISTERED;
                        id_in       = free_handle;
                        cmd.load_en = slot_sel;
                        count_in    = count_ff + CNT_BITS'(1);
                        in_use_in   = in_use_ff | (HANDLE_COUNT'(1) << free_handle);
                     end
                  end
                  OP_UNREGISTER: begin
                     strobe_in = 1'b1;
                     if (found) begin
                        cmd.shift_en = shift_mask;
                        count_in     = count_ff - CNT_BITS'(1);
                        in_use_in    = in_use_ff & ~(HANDLE_COUNT'(1) << req_timer_id);
                     end
                  end
                  OP_TICK: begin
                     state_in = ST_WALK;
                     step_in  = '0;
                     now_in   = req_now;
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            // rotate the ring one place; the head goes to the tail
            cmd.shift_en = '1;
            if (fire) begin
               strobe_in = 1'b1;
               kind_in   = KIND_FIRED;
               id_in     = head_entry.handle;
               last_in   = 1'b0;
            end
            step_in = IDX_BITS'(step_ff + 1'b1);
            if (step_ff == IDX_BITS'(MAX_TIMERS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         in_use_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         in_use_ff <= in_use_in;
         strobe_ff <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      now_ff  <= now_in;
      kind_ff <= kind_in;
      id_ff   <= id_in;
      last_ff <= last_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_result_id   = id_ff;
   assign rsp_last_of_run = last_ff;

endmodule

[src/periodic_timer_table.sv]
// Register, unregister and no-op commands leave busy low, so the next one
// may start at once; each result beat is registered and appears in the cycle
// after start. A tick rotates the whole cell ring once, one entry per cycle,
// holding busy through the walk and done states; its fired and done beats
// are registered likewise. Results cannot be stalled. Synchronous reset
// empties the table and frees all handles; entry contents stay as they are.
// ----------------------------------------------------------------------------
// Periodic timer table
// Ordered list of periodic timers held in a ring of cells with a sequencer.
// ----------------------------------------------------------------------------
module periodic_timer_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [ptt_pkg::OPCODE_BITS-1:0] req_opcode,
   input  logic [ptt_pkg::NOW_BITS-1:0]    req_now_tick,
   input  logic [ptt_pkg::PERIOD_BITS-1:0] req_period,
   input  logic [ptt_pkg::HANDLE_BITS-1:0] req_timer_id,
   output logic                            rsp_strobe,
   output logic [ptt_pkg::KIND_BITS-1:0]   rsp_kind,
   output logic [ptt_pkg::HANDLE_BITS-1:0] rsp_result_id,
   output logic                            rsp_last_of_run
);
   import ptt_pkg::*;

   cell_cmd_type          cmd;
   entry_type             cell_entry [MAX_TIMERS];
   logic [MAX_TIMERS-1:0] match_vec;

   ptt_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_now_tick    (req_now_tick),
      .req_period      (req_period),
      .req_timer_id    (req_timer_id),
      .head_entry      (cell_entry[0]),
      .match_vec       (match_vec),
      .cmd             (cmd),
      .rsp_strobe      (rsp_strobe),
      .rsp_kind        (rsp_kind),
      .rsp_result_id   (rsp_result_id),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // build the ring; the last cell takes the head back with its stamp
   for (genvar j = 0; j < MAX_TIMERS; j++) begin : g_cell
      entry_type next_entry;

      if (j == MAX_TIMERS - 1) begin : g_tail
         assign next_entry = cmd.wrap_entry;
      end else begin : g_body
         assign next_entry = cell_entry[j+1];
      end

      ptt_cell u_cell (
         .clock      (clock),
         .load_en    (cmd.load_en[j]),
         .shift_en   (cmd.shift_en[j]),
         .load_entry (cmd.load_entry),
         .next_entry (next_entry),
         .match_id   (cmd.match_id),
         .entry      (cell_entry[j]),
         .match      (match_vec[j])
      );
   end

endmodule

[tb/ptt_table_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Periodic timer table checker
// Watches the command and result channels, keeps its own copy of the timer
// list, predicts every result beat and compares it with what the block sends.
// ----------------------------------------------------------------------------
module ptt_table_checker
   import ptt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  logic [OPCODE_BITS-1:0] req_opcode,
   input  logic [NOW_BITS-1:0]    req_now_tick,
   input  logic [PERIOD_BITS-1:0] req_period,
   input  logic [HANDLE_BITS-1:0] req_timer_id,
   input  logic                   rsp_strobe,
   input  logic [KIND_BITS-1:0]   rsp_kind,
   input  logic [HANDLE_BITS-1:0] rsp_result_id,
   input  logic                   rsp_last_of_run,
   output int                     mismatch_count,
   output int                     outstanding
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      kind_type               kind;
      logic [HANDLE_BITS-1:0] id;
      logic                   last;
   } timer_beat_type;

   // Own copy of the timer list
   logic [HANDLE_BITS-1:0]  slot_handle [MAX_TIMERS];
   logic [PERIOD_BITS-1:0]  slot_period [MAX_TIMERS];
   logic [TICK_BITS-1:0]    slot_last   [MAX_TIMERS];
   int                      slot_count;
   logic [HANDLE_COUNT-1:0] handles_taken;

   timer_beat_type due_beats[$];
   int             errors = 0;

   task automatic queue_beat(input kind_type kind, input logic [HANDLE_BITS-1:0] id,
                             input logic last);
      timer_beat_type b;
      b.kind = kind;
      b.id   = id;
      b.last = last;
      due_beats.push_back(b);
   endtask

   // Update the list for one accepted command and queue the beats it causes
   task automatic apply_timer_command(input opcode_type op,
                                      input logic [NOW_BITS-1:0] now,
                                      input logic [PERIOD_BITS-1:0] period,
                                      input logic [HANDLE_BITS-1:0] id);
      int                   free_handle;
      int                   pos;
      logic [TICK_BITS-1:0] now_t;
      logic [TICK_BITS-1:0] elapsed;
      now_t = now[TICK_BITS-1:0];
      case (op)
         OP_REGISTER: begin
            free_handle = HANDLE_COUNT;
            for (int h = HANDLE_COUNT - 1; h >= 0; h--)
               if (!handles_taken[h]) free_handle = h;
            if (slot_count >= MAX_TIMERS || free_handle == HANDLE_COUNT) begin
               queue_beat(KIND_FULL, '0, 1'b1);
            end else begin
               slot_handle[slot_count] = free_handle[HANDLE_BITS-1:0];
               slot_period[slot_count] = period;
               slot_last[slot_count]   = now_t;
               slot_count++;
               handles_taken[free_handle] = 1'b1;
               queue_beat(KIND_REGISTERED, free_handle[HANDLE_BITS-1:0], 1'b1);
            end
         end
         OP_UNREGISTER: begin
            pos = -1;
            for (int i = slot_count - 1; i >= 0; i--)
               if (slot_handle[i] == id) pos = i;
            // close the gap, keeping list order
            if (pos >= 0) begin
               for (int i = pos; i + 1 < slot_count; i++) begin
                  slot_handle[i] = slot_handle[i+1];
                  slot_period[i] = slot_period[i+1];
                  slot_last[i]   = slot_last[i+1];
               end
               slot_count--;
               handles_taken[id] = 1'b0;
            end
            queue_beat(KIND_DONE, '0, 1'b1);
         end
         OP_TICK: begin
            for (int i = 0; i < slot_count; i++) begin
               elapsed = now_t - slot_last[i];
               if (elapsed >= slot_period[i]) begin
                  slot_last[i] = now_t;
                  queue_beat(KIND_FIRED, slot_handle[i], 1'b0);
               end
            end
            queue_beat(KIND_DONE, '0, 1'b1);
         end
         default: begin
            queue_beat(KIND_DONE, '0, 1'b1);
         end
      endcase
   endtask

   // Compare one result beat with the oldest expectation
   task automatic check_beat();
      timer_beat_type want;
      if (due_beats.size() == 0) begin
         errors++;
         if (errors <= REPORT_LIMIT)
            $display("%0t: unexpected result beat kind %0d id %0d last %0d",
                     $realtime, rsp_kind, rsp_result_id, rsp_last_of_run);
      end else begin
         want = due_beats.pop_front();
         if (want.kind !== rsp_kind || want.id !== rsp_result_id ||
             want.last !== rsp_last_of_run) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: result beat mismatch: kind %0d/%0d id %0d/%0d %s",
                        $realtime, want.kind, rsp_kind, want.id, rsp_result_id,
                        $sformatf("last %0d/%0d (exp/got)", want.last,
                                  rsp_last_of_run));
         end
      end
   endtask

   // Check results first, then predict the command accepted at this edge
   always @(posedge clock) begin
      if (reset) begin
         slot_count    = 0;
         handles_taken = '0;
         due_beats.delete();
      end else begin
         if (rsp_strobe) check_beat();
         if (start && !busy)
            apply_timer_command(opcode_type'(req_opcode), req_now_tick, req_period,
                                req_timer_id);
      end
      mismatch_count <= errors;
      outstanding    <= due_beats.size();
   end

endmodule

[tb/tb_periodic_timer_table.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Periodic timer table testbench
// Drives register, unregister, tick and no-op commands in random bursts,
// first a directed sequence over the corner cases, then random traffic that
// alternates between filling and draining the table while time advances.
// ----------------------------------------------------------------------------
module tb_periodic_timer_table;
   import ptt_pkg::*;

   localparam int RANDOM_ITEMS = 400;
   localparam int DRAIN_CYCLES = 24;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [OPCODE_BITS-1:0] req_opcode   = '0;
   logic [NOW_BITS-1:0]    req_now_tick = '0;
   logic [PERIOD_BITS-1:0] req_period   = '0;
   logic [HANDLE_BITS-1:0] req_timer_id = '0;
   logic                   rsp_strobe;
   logic [KIND_BITS-1:0]   rsp_kind;
   logic [HANDLE_BITS-1:0] rsp_result_id;
   logic                   rsp_last_of_run;
   int                     fail_total;
   int                     beats_pending;
   int                     burst_left = 0;

   always #5 clock = ~clock;

   periodic_timer_table dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_now_tick    (req_now_tick),
      .req_period      (req_period),
      .req_timer_id    (req_timer_id),
      .rsp_strobe      (rsp_strobe),
      .rsp_kind        (rsp_kind),
      .rsp_result_id   (rsp_result_id),
      .rsp_last_of_run (rsp_last_of_run)
   );

   ptt_table_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_now_tick    (req_now_tick),
      .req_period      (req_period),
      .req_timer_id    (req_timer_id),
      .rsp_strobe      (rsp_strobe),
      .rsp_kind        (rsp_kind),
      .rsp_result_id   (rsp_result_id),
      .rsp_last_of_run (rsp_last_of_run),
      .mismatch_count  (fail_total),
      .outstanding     (beats_pending)
   );

   // Present one command beat, hold it until accepted, then maybe idle
   task automatic issue(input opcode_type op, input logic [NOW_BITS-1:0] now,
                        input logic [PERIOD_BITS-1:0] period,
                        input logic [HANDLE_BITS-1:0] id);
      req_opcode   <= op;
      req_now_tick <= now;
      req_period   <= period;
      req_timer_id <= id;
      start        <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(0, 6);
      end else begin
         burst_left--;
      end
   endtask

   // Mostly short intervals so timers fire often; a few extremes
   function automatic logic [PERIOD_BITS-1:0] pick_period();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return $urandom();
         default: return $urandom_range(1, 48);
      endcase
   endfunction

   // Hard limit on run time
   initial begin
      #2_000_000;
      $display("tb_periodic_timer_table NOT OK");
      $finish;
   end

   initial begin
      logic [NOW_BITS-1:0] sys_now;
      opcode_type          op;
      int                  roll;
      bit                  fill_phase;
      sys_now = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero interval, wrap of the tick counter, unknown handle, no-op
      issue(OP_REGISTER, 32'h0, 32'h0, 4'h0);
      issue(OP_TICK, 32'h0, 32'h0, 4'h0);
      issue(OP_REGISTER, '1, '1, 4'h0);
      issue(OP_TICK, 32'hFFFF_FFFE, 32'h0, 4'h0);
      issue(OP_TICK, 32'hFFFF_FFFE, '1, 4'h0);
      issue(OP_UNREGISTER, '1, '1, 4'hF);
      issue(OP_NOP, '1, '1, 4'hF);
      issue(OP_UNREGISTER, 32'h0, 32'h0, 4'h0);
      // fill the table, then one register too many
      for (int i = 0; i < MAX_TIMERS; i++)
         issue(OP_REGISTER, 32'h100 + i, $urandom_range(0, 20),
               HANDLE_BITS'($urandom()));
      issue(OP_TICK, 32'h110, $urandom(), HANDLE_BITS'($urandom()));
      // free a middle handle and take it back at the end of the list
      issue(OP_UNREGISTER, $urandom(), $urandom(), 4'h7);
      issue(OP_REGISTER, 32'h120, 32'h5, 4'h0);
      issue(OP_TICK, 32'h130, 32'h0, 4'h0);
      sys_now = 32'h130;

      // Random: alternate fill and drain phases while time moves on
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         fill_phase = ((n / 50) % 2) == 1;
         roll = $urandom_range(0, 99);
         if (roll < 5)                          op = OP_NOP;
         else if (roll < (fill_phase ? 50 : 15)) op = OP_REGISTER;
         else if (roll < (fill_phase ? 70 : 65)) op = OP_UNREGISTER;
         else                                    op = OP_TICK;

         case ($urandom_range(0, 19))
            0:       sys_now = $urandom();
            1:       sys_now = 32'hFFFF_FFFF - $urandom_range(0, 30);
            default: sys_now = sys_now + $urandom_range(0, 12);
         endcase

         case (op)
            OP_REGISTER: issue(op, sys_now, pick_period(), HANDLE_BITS'($urandom()));
            OP_TICK:     issue(op, sys_now, $urandom(), HANDLE_BITS'($urandom()));
            default:     issue(op, $urandom(), $urandom(), HANDLE_BITS'($urandom()));
         endcase
      end
      start <= 1'b0;

      // Drain outstanding beats, then give the verdict
      while (beats_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_total == 0)
         $display("tb_periodic_timer_table OK");
      else
         $display("tb_periodic_timer_table NOT OK");
      $finish;
   end

endmodule

[sim.f]
src/ptt_pkg.sv
src/ptt_cell.sv
src/ptt_seq.sv
src/periodic_timer_table.sv
tb/ptt_table_checker.sv
tb/tb_periodic_timer_table.sv
